// ----- hdl/brf_pkg.sv -----
package brf_pkg;

    // fixed field widths of the stream beats
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CFG_W    = 7;
    localparam int unsigned FILL_W   = 7;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 32;

    // reset value of the capacity register
    localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

    // operation carried on the slave tuser bit
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // commands from controller to datapath
    typedef struct packed
    {
        logic load;
        logic exec;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed
    {
        logic out_free;
    } status_t;

endpackage

// ----- hdl/brf_ctrl.sv -----
module brf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  brf_pkg::status_t status,
    output brf_pkg::cmd_t    cmd
);

    brf_pkg::state_t state_reg;
    brf_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = brf_pkg::ST_EXEC;
                end
            end
            brf_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = brf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            brf_pkg::ST_EXEC:
            begin
                cmd.exec = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/brf_datapath.sv -----
module brf_datapath
#(
    parameter int unsigned RING_DEPTH = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  brf_pkg::cmd_t                  cmd,
    output brf_pkg::status_t               status,
    input  logic                           cfg_wr_en,
    input  logic [brf_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic [brf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brf_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tuser
);

    localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned EW = ((CW > brf_pkg::CFG_W) ? CW : brf_pkg::CFG_W) + 1;
    localparam logic [EW-1:0] DEPTH_EXT = EW'(RING_DEPTH);
    localparam logic [EW-1:0] ONE_EXT   = EW'(1);

    logic [brf_pkg::DATA_W-1:0] mem [RING_DEPTH];

    logic [brf_pkg::CFG_W-1:0]  slots_reg;
    logic [PW-1:0]              wptr_reg;
    logic [PW-1:0]              wptr_next;
    logic [PW-1:0]              rptr_reg;
    logic [PW-1:0]              rptr_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       mode_reg;
    logic [brf_pkg::DATA_W-1:0] data_reg;
    logic [brf_pkg::DATA_W-1:0] rd_data_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [brf_pkg::M_DATA_W-1:0] out_data_reg;
    logic                       out_ok_reg;

    logic [EW-1:0]              slots_ext;
    logic [EW-1:0]              cap_ext;
    logic [CW-1:0]              cap;
    logic                       push_ok;
    logic                       pop_ok;
    logic [CW:0]                winc;
    logic [CW:0]                rinc;
    logic [brf_pkg::DATA_W-1:0] byte_out;
    logic                       full_next;
    logic                       empty_next;
    logic [brf_pkg::M_DATA_W-1:0] out_data_next;

    // capacity register; the user must write it only while idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= brf_pkg::SLOTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            slots_reg <= cfg_wr_data;
        end
    end

    // active capacity clamped to 1..depth
    always_comb
    begin
        slots_ext = EW'(slots_reg);
        if (slots_ext == '0)
        begin
            cap_ext = ONE_EXT;
        end
        else if (slots_ext > DEPTH_EXT)
        begin
            cap_ext = DEPTH_EXT;
        end
        else
        begin
            cap_ext = slots_ext;
        end
        cap = CW'(cap_ext);
    end

    // capture the beat and read the slot a pop would take
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= s_tuser;
            data_reg    <= s_tdata;
            rd_data_reg <= mem[rptr_reg];
        end
    end

    // store write on an accepted push
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok)
        begin
            mem[wptr_reg] <= data_reg;
        end
    end

    // decision and pointer, count update
    always_comb
    begin
        push_ok    = (mode_reg == brf_pkg::MODE_PUSH) && (count_reg < cap);
        pop_ok     = (mode_reg == brf_pkg::MODE_POP) && (count_reg != '0);
        winc       = (CW + 1)'(wptr_reg) + 1'b1;
        rinc       = (CW + 1)'(rptr_reg) + 1'b1;
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        byte_out   = '0;
        if (push_ok)
        begin
            wptr_next  = (winc < (CW + 1)'(cap)) ? PW'(winc) : '0;
            count_next = count_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rptr_next  = (rinc < (CW + 1)'(cap)) ? PW'(rinc) : '0;
            count_next = count_reg - 1'b1;
            byte_out   = rd_data_reg;
        end
        empty_next = (count_next == '0);
        full_next  = (count_next >= cap);
    end

    // result beat packing
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[7:0]   = byte_out;
        out_data_next[14:8]  = brf_pkg::FILL_W'(count_next);
        out_data_next[15]    = empty_next;
        out_data_next[16]    = full_next;
        out_data_next[22:17] = brf_pkg::POS_W'(wptr_next);
        out_data_next[28:23] = brf_pkg::POS_W'(rptr_next);
    end

    // queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_data_reg <= out_data_next;
            out_ok_reg   <= push_ok || pop_ok;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_ok_reg;

endmodule

// ----- hdl/byte_ring_fifo.sv -----
// Byte FIFO in a ring store of RING_DEPTH slots. Each slave beat is one operation: tuser 0
// pushes the byte in tdata, tuser 1 pops one. Every operation returns exactly one master beat
// with the outcome (tuser: 1 when the push was stored or the pop returned data) and the queue
// status after it. A push to a full queue is dropped; a pop from an empty queue returns 0.
// cfg_wr_data sets the slots in use (0 acts as 1, values above RING_DEPTH act as RING_DEPTH);
// write it only while no operation is in flight. Lowering it below the fill leaves the queue
// full until drained, and a slot never written after such a change reads as undefined.
// An operation runs in order through ST_IDLE, which captures the beat and reads the store at the
// read position, and ST_EXEC, which waits for a free output register, then decides, writes the
// store and updates positions and count into the output register. The next beat is taken while a
// result still waits on the master side.
module byte_ring_fifo
#(
    parameter int unsigned RING_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [brf_pkg::CFG_W-1:0]     cfg_wr_data,    // slots_in_use
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [brf_pkg::S_DATA_W-1:0]  s_tdata,        // data_in[7:0]
    input  logic                          s_tuser,        // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_out[7:0], fill_count[14:8], is_empty[15], is_full[16],
    // write_position[22:17], read_position[28:23], zero[31:29]
    output logic [brf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser         // ok
);

    brf_pkg::cmd_t    cmd;
    brf_pkg::status_t status;

    // sequencing
    brf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // store, positions and result register
    brf_datapath
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
